// ----- rtl/core/vu32d_pkg.sv -----
package vu32d_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_SUCCESS  = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_PARSE    = 2'd2
  } status_t;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned GROUP_W = 7;

  // One input item: a byte of the buffer, or the end-of-buffer marker.
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              buffer_exhausted;
  } in_t;

  // One result item.
  typedef struct packed {
    status_t            status;
    logic [VALUE_W-1:0] decoded_value;
    logic [COUNT_W-1:0] bytes_consumed;
  } out_t;

endpackage

// ----- rtl/core/vu32d_step.sv -----
module vu32d_step #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  vu32d_pkg::in_t                                   item,
  input  logic [VALUE_BITS-1:0]                            acc,
  input  logic [$clog2((VALUE_BITS+6)/7+1)-1:0]            grp,
  input  logic                                             ovf,
  input  logic [vu32d_pkg::COUNT_W-1:0]                    cnt,
  output logic [VALUE_BITS-1:0]                            acc_next,
  output logic [$clog2((VALUE_BITS+6)/7+1)-1:0]            grp_next,
  output logic                                             ovf_next,
  output logic [vu32d_pkg::COUNT_W-1:0]                    cnt_next,
  output logic                                             emit,
  output vu32d_pkg::out_t                                  result
);

  localparam int unsigned GROUPS = (VALUE_BITS + 6) / 7;
  localparam int unsigned GW     = $clog2(GROUPS + 1);
  localparam int unsigned SW     = $clog2(GROUPS * 7 + 8);
  localparam int unsigned GRP_BITS = vu32d_pkg::GROUP_W;

  logic [vu32d_pkg::COUNT_W-1:0]     cnt_inc;
  logic [SW-1:0]                     shift;
  logic [SW-1:0]                     left;
  logic                              shift_full;
  logic                              left_small;
  logic [vu32d_pkg::BYTE_W-1:0]      high_part;
  logic                              too_wide;
  logic                              last_group;
  logic                              term;
  logic [VALUE_BITS+GRP_BITS-1:0]    placed;
  logic [VALUE_BITS-1:0]             added;

  always_comb begin
    cnt_inc    = (cnt == {vu32d_pkg::COUNT_W{1'b1}}) ? cnt
                                                     : cnt + vu32d_pkg::COUNT_W'(1);
    shift      = SW'(grp) * SW'(GRP_BITS);
    shift_full = (shift >= SW'(VALUE_BITS));
    left       = SW'(VALUE_BITS) - shift;
    left_small = !shift_full && (left < SW'(GRP_BITS));
    high_part  = item.data_byte >> left[2:0];
    too_wide   = left_small && (high_part != '0);
    last_group = (shift + SW'(GRP_BITS)) >= SW'(VALUE_BITS);
    term       = !item.data_byte[vu32d_pkg::BYTE_W-1];
    placed     = (VALUE_BITS+GRP_BITS)'(item.data_byte[GRP_BITS-1:0]) << shift;
    added      = acc + placed[VALUE_BITS-1:0];
  end

  always_comb begin
    acc_next              = acc;
    grp_next              = grp;
    ovf_next              = ovf;
    cnt_next              = cnt_inc;
    emit                  = 1'b0;
    result.status         = vu32d_pkg::ST_SUCCESS;
    result.decoded_value  = '0;
    result.bytes_consumed = cnt_inc;

    if (item.buffer_exhausted) begin
      // The number ends without its terminating byte.
      emit                  = 1'b1;
      result.status         = vu32d_pkg::ST_PARSE;
      result.bytes_consumed = cnt;
    end else if (ovf || shift_full || too_wide) begin
      // Skip up to and including the terminating byte.
      ovf_next = 1'b1;
      if (term) begin
        emit          = 1'b1;
        result.status = vu32d_pkg::ST_OVERFLOW;
      end
    end else if (term) begin
      emit                 = 1'b1;
      result.status        = vu32d_pkg::ST_SUCCESS;
      result.decoded_value = vu32d_pkg::VALUE_W'(added);
    end else begin
      acc_next = added;
      grp_next = grp + GW'(1);
      ovf_next = last_group;
    end

    if (emit) begin
      acc_next = '0;
      grp_next = '0;
      ovf_next = 1'b0;
      cnt_next = '0;
    end
  end

endmodule

// ----- rtl/core/varint_u32_decoder.sv -----
// Unsigned base-128 varint decoder, one byte per transfer.
//
// The byte channel (byte_valid, byte_ready, byte_data) carries one byte of
// the buffer per transfer, or an end-of-buffer marker when buffer_exhausted
// is set. The result channel (result_valid, result_ready, result_data)
// carries one result per finished number: status, the decoded value, and
// the number of bytes taken for it, saturating at 255.
//
// A byte is captured in an input register on its transfer edge and decoded
// from there into the result register once that register is free or is
// being emptied, and the result is offered from that result register. The
// decode step is one short shift, add and compare on the running state, so
// one byte per cycle is sustained as long as results are taken.
//
// When the receiver stalls, the pending result holds in the result
// register; the byte sitting in the input register waits, and byte_ready
// drops once that register is also full. Reset clears the running value,
// the group and byte counts, the overflow flag and both valid flags.
module varint_u32_decoder #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  output logic             byte_ready,
  input  vu32d_pkg::in_t   byte_data,
  output logic             result_valid,
  input  logic             result_ready,
  output vu32d_pkg::out_t  result_data
);

  localparam int unsigned GROUPS = (VALUE_BITS + 6) / 7;
  localparam int unsigned GW     = $clog2(GROUPS + 1);

  // Input register.
  logic                          s1_valid;
  vu32d_pkg::in_t                s1_item;

  // Running decode state.
  logic [VALUE_BITS-1:0]         acc;
  logic [GW-1:0]                 grp;
  logic                          ovf;
  logic [vu32d_pkg::COUNT_W-1:0] cnt;

  logic [VALUE_BITS-1:0]         acc_next;
  logic [GW-1:0]                 grp_next;
  logic                          ovf_next;
  logic [vu32d_pkg::COUNT_W-1:0] cnt_next;
  logic                          emit;
  vu32d_pkg::out_t               step_result;

  // The buffered byte is decoded when the result register is free or is
  // being emptied in this cycle.
  logic advance;

  assign advance    = s1_valid && (!result_valid || result_ready);
  assign byte_ready = !s1_valid || advance;

  vu32d_step #(
    .VALUE_BITS (VALUE_BITS)
  ) u_step (
    .item     (s1_item),
    .acc      (acc),
    .grp      (grp),
    .ovf      (ovf),
    .cnt      (cnt),
    .acc_next (acc_next),
    .grp_next (grp_next),
    .ovf_next (ovf_next),
    .cnt_next (cnt_next),
    .emit     (emit),
    .result   (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      acc          <= '0;
      grp          <= '0;
      ovf          <= 1'b0;
      cnt          <= '0;
    end else begin
      if (byte_ready) begin
        s1_valid <= byte_valid;
      end
      // A new result may replace the one taken in this same cycle.
      if (advance && emit) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (advance) begin
        acc <= acc_next;
        grp <= grp_next;
        ovf <= ovf_next;
        cnt <= cnt_next;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (byte_ready && byte_valid) begin
      s1_item <= byte_data;
    end
    if (advance && emit) begin
      result_data <= step_result;
    end
  end

  // A byte that could not be decoded stays put in the input register.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_item))
    else $error("input register changed while stalled");

  // A successful number always took at least one byte.
  a_success_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.status == vu32d_pkg::ST_SUCCESS
      |-> result_data.bytes_consumed != '0)
    else $error("success reported with no bytes consumed");

  // The group count never runs past the last group that fits.
  a_group_bound: assert property (@(posedge clk) disable iff (rst)
    grp <= GW'(GROUPS))
    else $error("group count out of range");

  // Once the value has overflowed, the running value is no longer grown.
  a_ovf_freeze: assert property (@(posedge clk) disable iff (rst)
    ovf && advance && !emit |=> $stable(acc) && $stable(grp))
    else $error("running value changed while skipping");

  // Status code 3 is never produced.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_data.status == vu32d_pkg::ST_SUCCESS ||
                      result_data.status == vu32d_pkg::ST_OVERFLOW ||
                      result_data.status == vu32d_pkg::ST_PARSE))
    else $error("invalid result status");

endmodule
